// File: rtl/sst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sst_pkg
// shared types and constants of the spectrum sweep tuner
// ---------------------------------------------------------------------------
package sst_pkg;

   // request command codes
   localparam logic [1:0] CMD_KEY   = 2'd0;
   localparam logic [1:0] CMD_FREQ  = 2'd1;
   localparam logic [1:0] CMD_LEVEL = 2'd2;

   // csr register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 30;
   localparam logic [CSR_INDEX_W-1:0] CSR_RSSI_FLOOR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPAN_HZ    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_HZ    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_FREQ   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FREQ   = 3'd4;

   // reset values
   localparam logic signed [7:0] FLOOR_RESET  = -8'sd120;
   localparam logic [27:0]       SPAN_RESET   = 28'd8000000;
   localparam logic [23:0]       STEP_RESET   = 24'd31250;
   localparam logic [29:0]       MIN_RESET    = 30'd862000000;
   localparam logic [29:0]       MAX_RESET    = 30'd928000000;
   localparam logic [29:0]       CENTER_RESET = 30'd895000000;
   localparam logic signed [7:0] CEIL_RESET   = -8'sd40;

   // tuning steps and ceiling limits
   localparam logic signed [31:0] STEP_FINE_HZ   = 32'sd250000;
   localparam logic signed [31:0] STEP_COARSE_HZ = 32'sd1000000;
   localparam logic signed [7:0]  CEIL_TOP_DBM   = -8'sd20;
   localparam logic signed [9:0]  CEIL_GAP_DB    = 10'sd20;
   localparam logic [7:0]         CEIL_STEP_DB   = 8'd5;
   localparam logic [7:0]         LEVEL_FULL     = 8'd255;

   // keypad codes
   localparam logic [6:0] KEY_FINE_DN_A   = 7'h2D;
   localparam logic [6:0] KEY_FINE_DN_B   = 7'h41;
   localparam logic [6:0] KEY_FINE_UP_A   = 7'h2F;
   localparam logic [6:0] KEY_FINE_UP_B   = 7'h42;
   localparam logic [6:0] KEY_COARSE_UP   = 7'h20;
   localparam logic [6:0] KEY_COARSE_DN   = 7'h2E;
   localparam logic [6:0] KEY_CEIL_UP     = 7'h50;
   localparam logic [6:0] KEY_CEIL_DN_A   = 7'h1B;
   localparam logic [6:0] KEY_CEIL_DN_B   = 7'h51;

   // queue between front and back, power of two
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      OP_NOP,
      OP_FINE_DN,
      OP_FINE_UP,
      OP_COARSE_UP,
      OP_COARSE_DN,
      OP_CEIL_UP,
      OP_CEIL_DN,
      OP_FREQ,
      OP_LEVEL
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_SUM,
      ST_CLAMP,
      ST_DIV,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      op_type            op;
      logic [7:0]        point_index;
      logic signed [7:0] rssi_sample;
   } entry_type;

   typedef struct packed {
      logic signed [7:0] rssi_floor;
      logic [27:0]       span_hz;
      logic [23:0]       step_hz;
      logic [29:0]       min_freq_hz;
      logic [29:0]       max_freq_hz;
   } cfg_type;

endpackage

// File: rtl/sst_channels_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sst channel interfaces
// request and response handshake channels of the tuner
// ---------------------------------------------------------------------------
interface sst_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [7:0]        key_byte;
   logic [7:0]        point_index;
   logic signed [7:0] rssi_sample;

   modport source (output valid, output cmd, output key_byte, output point_index,
                   output rssi_sample, input ready);
   modport sink (input valid, input cmd, input key_byte, input point_index,
                 input rssi_sample, output ready);
endinterface

interface sst_rsp_if;
   logic              valid;
   logic              ready;
   logic [29:0]       freq_hz;
   logic [7:0]        level;
   logic [29:0]       center_now_hz;
   logic signed [7:0] ceil_now_dbm;
   logic              tuning_changed;

   modport source (output valid, output freq_hz, output level, output center_now_hz,
                   output ceil_now_dbm, output tuning_changed, input ready);
   modport sink (input valid, input freq_hz, input level, input center_now_hz,
                 input ceil_now_dbm, input tuning_changed, output ready);
endinterface

// File: rtl/sst_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sst_front
// accepts requests, decodes keys and saturates the point index
// ---------------------------------------------------------------------------
module sst_front
   import sst_pkg::*;
#(
   parameter int SCAN_POINTS = 256
) (
   sst_req_if.sink   req,
   input  logic      q_full,
   output logic      push,
   output entry_type push_entry
);

   localparam int IdxMax = (SCAN_POINTS - 1 > 255) ? 255 : SCAN_POINTS - 1;
   localparam logic [7:0] IDX_MAX = IdxMax[7:0];

   op_type key_op;

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   // key decode, releases and unknown codes do nothing
   always_comb begin
      key_op = OP_NOP;
      if (req.key_byte[7]) begin
         case (req.key_byte[6:0])
            KEY_FINE_DN_A, KEY_FINE_DN_B: key_op = OP_FINE_DN;
            KEY_FINE_UP_A, KEY_FINE_UP_B: key_op = OP_FINE_UP;
            KEY_COARSE_UP:                key_op = OP_COARSE_UP;
            KEY_COARSE_DN:                key_op = OP_COARSE_DN;
            KEY_CEIL_UP:                  key_op = OP_CEIL_UP;
            KEY_CEIL_DN_A, KEY_CEIL_DN_B: key_op = OP_CEIL_DN;
            default:                      key_op = OP_NOP;
         endcase
      end
   end

   always_comb begin
      push_entry.rssi_sample = req.rssi_sample;
      push_entry.point_index = (req.point_index > IDX_MAX) ? IDX_MAX : req.point_index;
      case (req.cmd)
         CMD_KEY:   push_entry.op = key_op;
         CMD_FREQ:  push_entry.op = OP_FREQ;
         CMD_LEVEL: push_entry.op = OP_LEVEL;
         default:   push_entry.op = OP_NOP;
      endcase
   end

endmodule

// File: rtl/sst_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sst_queue
// short fifo of decoded requests between front and back
// ---------------------------------------------------------------------------
module sst_queue
   import sst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_entry
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   // no request is taken while in reset
   assign full      = reset || (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/sst_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sst_back
// executes decoded requests, holds tuning state and the response register
// ---------------------------------------------------------------------------
module sst_back
   import sst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_not_empty,
   input  entry_type q_entry,
   output logic      q_pop,
   sst_rsp_if.source rsp
);

   back_state_type     state_ff, state_in;
   op_type             op_ff, op_in;
   logic [7:0]         idx_ff, idx_in;
   logic signed [7:0]  rssi_ff, rssi_in;
   logic [29:0]        center_ff, center_in;
   logic signed [7:0]  ceil_ff, ceil_in;
   logic signed [31:0] nc_ff, nc_in;
   logic signed [31:0] lo_ff, lo_in;
   logic signed [31:0] hi_ff, hi_in;
   logic [31:0]        prod_ff, prod_in;
   logic signed [34:0] base_ff, base_in;
   logic signed [34:0] sum_ff, sum_in;
   logic [7:0]         dvsr_ff, dvsr_in;
   logic [7:0]         rem_ff, rem_in;
   logic [7:0]         quo_ff, quo_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [29:0]        freq_ff, freq_in;
   logic [7:0]         level_ff, level_in;
   logic               chg_ff, chg_in;
   logic               ov_ff, ov_in;
   logic [29:0]        ofreq_ff, ofreq_in;
   logic [7:0]         olevel_ff, olevel_in;
   logic [29:0]        ocenter_ff, ocenter_in;
   logic signed [7:0]  oceil_ff, oceil_in;
   logic               ochg_ff, ochg_in;

   logic signed [31:0] center_s;
   logic signed [31:0] half_span_s;
   logic signed [9:0]  ceil_low_lim;
   logic signed [8:0]  val9;
   logic signed [8:0]  range9;
   logic [15:0]        num;
   logic [8:0]         rem_sh;
   logic               ge;
   logic signed [34:0] min_x;
   logic signed [34:0] max_x;
   logic               below_min;
   logic               above_max;

   assign rsp.valid          = ov_ff;
   assign rsp.freq_hz        = ofreq_ff;
   assign rsp.level          = olevel_ff;
   assign rsp.center_now_hz  = ocenter_ff;
   assign rsp.ceil_now_dbm   = oceil_ff;
   assign rsp.tuning_changed = ochg_ff;

   always_comb begin
      center_s     = signed'({2'b00, center_ff});
      half_span_s  = signed'(32'(cfg.span_hz[27:1]));
      ceil_low_lim = 10'(cfg.rssi_floor) + CEIL_GAP_DB;
      val9         = 9'(rssi_ff) - 9'(cfg.rssi_floor);
      range9       = 9'(ceil_ff) - 9'(cfg.rssi_floor);
      num          = {val9[7:0], 8'd0} - {8'd0, val9[7:0]};
      rem_sh       = {rem_ff, quo_ff[7]};
      ge           = (rem_sh >= {1'b0, dvsr_ff});
      min_x        = signed'(35'(cfg.min_freq_hz));
      max_x        = signed'(35'(cfg.max_freq_hz));
      below_min    = (sum_ff < min_x);
      // raise to min first, then lower to max so max wins on an inverted band
      above_max    = below_min ? (cfg.min_freq_hz > cfg.max_freq_hz) : (sum_ff > max_x);

      state_in   = state_ff;
      op_in      = op_ff;
      idx_in     = idx_ff;
      rssi_in    = rssi_ff;
      center_in  = center_ff;
      ceil_in    = ceil_ff;
      nc_in      = nc_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      prod_in    = prod_ff;
      base_in    = base_ff;
      sum_in     = sum_ff;
      dvsr_in    = dvsr_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      freq_in    = freq_ff;
      level_in   = level_ff;
      chg_in     = chg_ff;
      ov_in      = ov_ff;
      ofreq_in   = ofreq_ff;
      olevel_in  = olevel_ff;
      ocenter_in = ocenter_ff;
      oceil_in   = oceil_ff;
      ochg_in    = ochg_ff;
      q_pop      = 1'b0;

      if (ov_ff && rsp.ready) begin
         ov_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               op_in    = q_entry.op;
               idx_in   = q_entry.point_index;
               rssi_in  = q_entry.rssi_sample;
               freq_in  = '0;
               level_in = '0;
               chg_in   = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            lo_in    = signed'(32'(cfg.min_freq_hz)) + half_span_s;
            hi_in    = signed'(32'(cfg.max_freq_hz)) - half_span_s;
            case (op_ff)
               OP_FINE_DN: begin
                  nc_in    = center_s - STEP_FINE_HZ;
                  chg_in   = 1'b1;
                  state_in = ST_CHECK;
               end
               OP_FINE_UP: begin
                  nc_in    = center_s + STEP_FINE_HZ;
                  chg_in   = 1'b1;
                  state_in = ST_CHECK;
               end
               OP_COARSE_UP: begin
                  nc_in    = center_s + STEP_COARSE_HZ;
                  chg_in   = 1'b1;
                  state_in = ST_CHECK;
               end
               OP_COARSE_DN: begin
                  nc_in    = center_s - STEP_COARSE_HZ;
                  chg_in   = 1'b1;
                  state_in = ST_CHECK;
               end
               OP_CEIL_UP: begin
                  chg_in = 1'b1;
                  if (ceil_ff < CEIL_TOP_DBM) begin
                     ceil_in = ceil_ff + signed'(CEIL_STEP_DB);
                  end
               end
               OP_CEIL_DN: begin
                  chg_in = 1'b1;
                  if (10'(ceil_ff) > ceil_low_lim) begin
                     ceil_in = ceil_ff - signed'(CEIL_STEP_DB);
                  end
               end
               OP_FREQ: begin
                  prod_in  = 32'(idx_ff) * 32'(cfg.step_hz);
                  base_in  = signed'(35'(center_ff)) - signed'(35'(cfg.span_hz[27:1]));
                  state_in = ST_SUM;
               end
               OP_LEVEL: begin
                  if (rssi_ff <= cfg.rssi_floor) begin
                     level_in = '0;
                  end else if (rssi_ff >= ceil_ff) begin
                     level_in = LEVEL_FULL;
                  end else begin
                     // quotient fits in 8 bits, so the top byte is a valid remainder
                     dvsr_in  = range9[7:0];
                     rem_in   = num[15:8];
                     quo_in   = num[7:0];
                     cnt_in   = '1;
                     state_in = ST_DIV;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_CHECK: begin
            if (nc_ff >= lo_ff && nc_ff <= hi_ff && !nc_ff[31]) begin
               center_in = nc_ff[29:0];
            end
            state_in = ST_DONE;
         end
         ST_SUM: begin
            sum_in   = base_ff + signed'(35'(prod_ff));
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (above_max) begin
               freq_in = cfg.max_freq_hz;
            end else if (below_min) begin
               freq_in = cfg.min_freq_hz;
            end else begin
               freq_in = sum_ff[29:0];
            end
            state_in = ST_DONE;
         end
         ST_DIV: begin
            // one restoring step per cycle
            rem_in = ge ? 8'(rem_sh - {1'b0, dvsr_ff}) : rem_sh[7:0];
            quo_in = {quo_ff[6:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               level_in = {quo_ff[6:0], ge};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!ov_ff || rsp.ready) begin
               ov_in      = 1'b1;
               ofreq_in   = freq_ff;
               olevel_in  = level_ff;
               ocenter_in = center_ff;
               oceil_in   = ceil_ff;
               ochg_in    = chg_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         center_ff <= CENTER_RESET;
         ceil_ff   <= CEIL_RESET;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         center_ff <= center_in;
         ceil_ff   <= ceil_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      rssi_ff    <= rssi_in;
      nc_ff      <= nc_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      prod_ff    <= prod_in;
      base_ff    <= base_in;
      sum_ff     <= sum_in;
      dvsr_ff    <= dvsr_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      freq_ff    <= freq_in;
      level_ff   <= level_in;
      chg_ff     <= chg_in;
      ofreq_ff   <= ofreq_in;
      olevel_ff  <= olevel_in;
      ocenter_ff <= ocenter_in;
      oceil_ff   <= oceil_in;
      ochg_ff    <= ochg_in;
   end

endmodule

// File: rtl/spectrum_sweep_tuner_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spectrum_sweep_tuner_unit
// sweep center and display ceiling controller for a spectrum display
// ---------------------------------------------------------------------------
// each request yields exactly one response. a front stage decodes the
// request (keypad byte to tuning op, point index saturated to the scan size)
// and drops it into a two-entry queue, so new requests are taken while the
// back stage works and while a finished response waits in its output
// register. the back stage handles one request at a time: ceiling keys,
// unknown keys, unused commands and out-of-range rssi samples pass exec
// and done, center steps add a window check, a frequency request does the
// 8x24 multiply in exec, then add and clamp, and an in-range rssi sample
// runs the 8-step restoring divider before done. csr writes take effect on
// the next edge and are expected only while no request is in flight.
// ---------------------------------------------------------------------------
module spectrum_sweep_tuner_unit
   import sst_pkg::*;
#(
   parameter int SCAN_POINTS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   sst_req_if.sink                req_chan,
   sst_rsp_if.source              rsp_chan,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   cfg_type   cfg_ff, cfg_in;

   // front to queue
   logic      push;
   entry_type push_entry;
   logic      q_full;

   // queue to back
   logic      q_pop;
   logic      q_not_empty;
   entry_type q_entry;

   // csr decode, writes outside the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_RSSI_FLOOR: cfg_in.rssi_floor  = signed'(csr_wdata[7:0]);
            CSR_SPAN_HZ:    cfg_in.span_hz     = csr_wdata[27:0];
            CSR_STEP_HZ:    cfg_in.step_hz     = csr_wdata[23:0];
            CSR_MIN_FREQ:   cfg_in.min_freq_hz = csr_wdata[29:0];
            CSR_MAX_FREQ:   cfg_in.max_freq_hz = csr_wdata[29:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rssi_floor  <= FLOOR_RESET;
         cfg_ff.span_hz     <= SPAN_RESET;
         cfg_ff.step_hz     <= STEP_RESET;
         cfg_ff.min_freq_hz <= MIN_RESET;
         cfg_ff.max_freq_hz <= MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request decode
   sst_front #(
      .SCAN_POINTS (SCAN_POINTS)
   ) u_front (
      .req        (req_chan),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   sst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_entry  (q_entry)
   );

   // execution and response register
   sst_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp         (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // a handled key never carries a frequency or level result
   a_key_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.tuning_changed |->
         rsp_chan.freq_hz == '0 && rsp_chan.level == '0)
      else $error("tuning response carries frequency or level");

   // a level result comes alone
   a_level_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.level != '0 |->
         rsp_chan.freq_hz == '0 && !rsp_chan.tuning_changed)
      else $error("level response mixed with other results");

   // the ceiling never climbs past one step above its top limit
   a_ceil_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.ceil_now_dbm <= CEIL_TOP_DBM + signed'(CEIL_STEP_DB))
      else $error("ceiling above its limit");

   // the queue only drains into the back stage when it holds a request
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty && !$past(reset))
      else $error("queue popped while empty");
`endif

endmodule
